// ===== sv/toeq_pkg.sv =====
// ----------------------------------------------------------------------------
// toeq_pkg
// shared types and constants of the time ordered event queue
// ----------------------------------------------------------------------------
package toeq_pkg;

    // default number of queue slots
    localparam int QUEUE_DEPTH_DEF = 64;

    // field widths of one stored event
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 3;
    localparam int JOB_W   = 16;
    localparam int ENTRY_W = TIME_W + KIND_W + JOB_W;
    localparam int OCC_W   = 7;

    // entry layout: time, kind, job from msb down
    localparam int JOB_LSB  = 0;
    localparam int KIND_LSB = JOB_W;
    localparam int TIME_LSB = JOB_W + KIND_W;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_LAST,
        ST_REM_HEAD,
        ST_REM_SHIFT
    } state_t;

endpackage

// ===== sv/toeq_ram.sv =====
// ----------------------------------------------------------------------------
// toeq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module toeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/time_ordered_event_queue_unit.sv =====
// ----------------------------------------------------------------------------
// time_ordered_event_queue_unit
// bounded priority queue of events kept sorted by time, earliest first
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. opcode 0 inserts the
// event (event_time, event_kind, job_number), opcode 1 removes the earliest
// event. Every item gives exactly one result, shown for one cycle with done
// high; the receiver cannot stall it, so it must take the result in that
// cycle. Events live in a ram with one write and one registered read port,
// kept sorted; equal times leave in arrival order. One comparator and the
// single ram port pair are reused step by step, so timing follows the number
// of entries moved: an insert scans down from the tail, moving each later
// event up one slot (an empty queue is written at once), a remove reads the
// head and shifts every other event down one slot, and a rejected item (full
// queue on insert, empty queue on remove) takes no step. The result appears
// the cycle after the last step; the next item may be started in that cycle.
// ----------------------------------------------------------------------------
module time_ordered_event_queue_unit
    import toeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              opcode,
    input  logic [TIME_W-1:0] event_time,
    input  logic [KIND_W-1:0] event_kind,
    input  logic [JOB_W-1:0]  job_number,
    output logic              done,
    output logic [1:0]        status,
    output logic [TIME_W-1:0] out_time,
    output logic [KIND_W-1:0] out_kind,
    output logic [JOB_W-1:0]  out_job,
    output logic [OCC_W-1:0]  occupancy
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // sequencer state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;      // slot whose read data arrives
    logic [CNT_W-1:0]   count_reg, count_next;  // stored events

    // event being inserted
    logic [ENTRY_W-1:0] new_entry_reg;
    logic [ENTRY_W-1:0] in_entry;

    // result registers
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [TIME_W-1:0]  out_time_reg, out_time_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [JOB_W-1:0]   out_job_reg, out_job_next;

    // ram ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               accept;
    logic               key_gt;     // the shared comparator
    logic               cnt_full;
    logic               cnt_zero;
    logic [IDX_W-1:0]   last_idx;

    assign in_entry = {event_time, event_kind, job_number};
    assign accept   = start && (state_reg == ST_IDLE);
    assign cnt_full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign cnt_zero = (count_reg == '0);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // stored event later than the new one: it moves up one slot
    assign key_gt = ram_rdata[TIME_LSB +: TIME_W] > new_entry_reg[TIME_LSB +: TIME_W];

    toeq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_INSERT)
                    begin
                        // scan downward from the tail
                        if (!cnt_full && !cnt_zero)
                        begin
                            state_next = ST_INS_SCAN;
                            cur_next   = last_idx;
                        end
                    end
                    else if (!cnt_zero)
                    begin
                        state_next = ST_REM_HEAD;
                        cur_next   = '0;
                    end
                end
            end
            ST_INS_SCAN:
            begin
                if (!key_gt)
                begin
                    state_next = ST_IDLE;
                end
                else if (cur_reg == '0)
                begin
                    state_next = ST_INS_LAST;
                end
                else
                begin
                    cur_next = cur_reg - IDX_W'(1);
                end
            end
            ST_INS_LAST:
            begin
                state_next = ST_IDLE;
            end
            ST_REM_HEAD:
            begin
                if (count_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_REM_SHIFT;
                    cur_next   = IDX_W'(1);
                end
            end
            ST_REM_SHIFT:
            begin
                if (cur_reg == last_idx)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ram control, count and results
    always_comb
    begin
        busy          = (state_reg != ST_IDLE);
        ram_we        = 1'b0;
        ram_waddr     = cur_reg;
        ram_wdata     = new_entry_reg;
        ram_raddr     = cur_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        out_time_next = out_time_reg;
        out_kind_next = out_kind_reg;
        out_job_next  = out_job_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_INSERT)
                    begin
                        out_time_next = '0;
                        out_kind_next = '0;
                        out_job_next  = '0;
                        if (cnt_full)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_FULL;
                        end
                        else if (cnt_zero)
                        begin
                            // first event goes straight to the head slot
                            ram_we      = 1'b1;
                            ram_waddr   = '0;
                            ram_wdata   = in_entry;
                            count_next  = count_reg + CNT_W'(1);
                            done_next   = 1'b1;
                            status_next = STATUS_DONE;
                        end
                        else
                        begin
                            ram_raddr = last_idx;
                        end
                    end
                    else
                    begin
                        if (cnt_zero)
                        begin
                            done_next     = 1'b1;
                            status_next   = STATUS_EMPTY;
                            out_time_next = '0;
                            out_kind_next = '0;
                            out_job_next  = '0;
                        end
                        else
                        begin
                            ram_raddr = '0;
                        end
                    end
                end
            end
            ST_INS_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg + IDX_W'(1);
                if (key_gt)
                begin
                    // move the later event up, look at the next one down
                    ram_wdata = ram_rdata;
                    ram_raddr = cur_reg - IDX_W'(1);
                end
                else
                begin
                    ram_wdata   = new_entry_reg;
                    count_next  = count_reg + CNT_W'(1);
                    done_next   = 1'b1;
                    status_next = STATUS_DONE;
                end
            end
            ST_INS_LAST:
            begin
                // every stored event was later: new one becomes the head
                ram_we      = 1'b1;
                ram_waddr   = '0;
                ram_wdata   = new_entry_reg;
                count_next  = count_reg + CNT_W'(1);
                done_next   = 1'b1;
                status_next = STATUS_DONE;
            end
            ST_REM_HEAD:
            begin
                out_time_next = ram_rdata[TIME_LSB +: TIME_W];
                out_kind_next = ram_rdata[KIND_LSB +: KIND_W];
                out_job_next  = ram_rdata[JOB_LSB +: JOB_W];
                status_next   = STATUS_DONE;
                ram_raddr     = IDX_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    count_next = count_reg - CNT_W'(1);
                    done_next  = 1'b1;
                end
            end
            ST_REM_SHIFT:
            begin
                // close the gap one slot at a time
                ram_we    = 1'b1;
                ram_waddr = cur_reg - IDX_W'(1);
                ram_wdata = ram_rdata;
                ram_raddr = cur_reg + IDX_W'(1);
                if (cur_reg == last_idx)
                begin
                    count_next = count_reg - CNT_W'(1);
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_entry_reg <= in_entry;
        end
        status_reg   <= status_next;
        out_time_reg <= out_time_next;
        out_kind_reg <= out_kind_next;
        out_job_reg  <= out_job_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_time  = out_time_reg;
    assign out_kind  = out_kind_reg;
    assign out_job   = out_job_reg;
    assign occupancy = OCC_W'(count_reg);

    // a result always follows an item taken or a working step
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != ST_IDLE || $past(start)))
        else $error("result without a preceding item");

    // the count moves only when a result is given
    a_count_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done_reg)
        else $error("event count changed without a result");

    // full report only at full depth, and the queue stays bounded
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STATUS_FULL) |-> cnt_full)
        else $error("full reported below queue depth");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STATUS_EMPTY) |-> cnt_zero)
        else $error("empty reported with stored events");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("event count above queue depth");

endmodule
